### rtl/heu_pkg.sv
// Shared constants and the entity lookup for the HTML entity unescape core.
`default_nettype none
package heu_pkg;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Longest name the lookup table can match
    localparam int TAB_NAME_LEN = 8;

    // Kinds of job handed from the front to the back
    localparam logic [1:0] JOB_BYTE = 2'd0;  // one plain byte
    localparam logic [1:0] JOB_CP   = 2'd1;  // UTF-8 encode a code point
    localparam logic [1:0] JOB_NAME = 2'd2;  // '&' + name (+ optional tail byte)

    // Pack a name of up to eight characters, first character in the low byte
    function automatic logic [63:0] nm(input string s);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 8; i++) r[i*8 +: 8] = s[i];
        return r;
    endfunction

    // Look up a name; returns {hit, code point}
    function automatic logic [16:0] ent_lookup(input logic [63:0] n, input logic [3:0] len);
        int          cp;
        logic        hit;
        logic [63:0] k;
        hit = 1'b1;
        cp  = 0;
        k   = n;
        // Clear bytes past the length so the key matches a zero-padded name
        for (int i = 0; i < 8; i++) if (i >= len) k[i*8 +: 8] = 8'h00;
        if (len == 4'd0) hit = 1'b0;
        else case (k)
            nm("nbsp"): cp=160; nm("iexcl"): cp=161; nm("cent"): cp=162; nm("pound"): cp=163;
            nm("curren"): cp=164; nm("yen"): cp=165; nm("brvbar"): cp=166; nm("sect"): cp=167;
            nm("uml"): cp=168; nm("copy"): cp=169; nm("ordf"): cp=170; nm("laquo"): cp=171;
            nm("not"): cp=172; nm("shy"): cp=173; nm("reg"): cp=174; nm("macr"): cp=175;
            nm("deg"): cp=176; nm("plusmn"): cp=177; nm("sup2"): cp=178; nm("sup3"): cp=179;
            nm("acute"): cp=180; nm("micro"): cp=181; nm("para"): cp=182; nm("middot"): cp=183;
            nm("cedil"): cp=184; nm("sup1"): cp=185; nm("ordm"): cp=186; nm("raquo"): cp=187;
            nm("frac14"): cp=188; nm("frac12"): cp=189; nm("frac34"): cp=190;
            nm("iquest"): cp=191; nm("Agrave"): cp=192; nm("Aacute"): cp=193;
            nm("Acirc"): cp=194; nm("Atilde"): cp=195; nm("Auml"): cp=196; nm("Aring"): cp=197;
            nm("AElig"): cp=198; nm("Ccedil"): cp=199; nm("Egrave"): cp=200;
            nm("Eacute"): cp=201; nm("Ecirc"): cp=202; nm("Euml"): cp=203;
            nm("Igrave"): cp=204; nm("Iacute"): cp=205; nm("Icirc"): cp=206; nm("Iuml"): cp=207;
            nm("ETH"): cp=208; nm("Ntilde"): cp=209; nm("Ograve"): cp=210; nm("Oacute"): cp=211;
            nm("Ocirc"): cp=212; nm("Otilde"): cp=213; nm("Ouml"): cp=214; nm("times"): cp=215;
            nm("Oslash"): cp=216; nm("Ugrave"): cp=217; nm("Uacute"): cp=218;
            nm("Ucirc"): cp=219; nm("Uuml"): cp=220; nm("Yacute"): cp=221; nm("THORN"): cp=222;
            nm("szlig"): cp=223; nm("agrave"): cp=224; nm("aacute"): cp=225; nm("acirc"): cp=226;
            nm("atilde"): cp=227; nm("auml"): cp=228; nm("aring"): cp=229; nm("aelig"): cp=230;
            nm("ccedil"): cp=231; nm("egrave"): cp=232; nm("eacute"): cp=233;
            nm("ecirc"): cp=234; nm("euml"): cp=235; nm("igrave"): cp=236;
            nm("iacute"): cp=237; nm("icirc"): cp=238; nm("iuml"): cp=239; nm("eth"): cp=240;
            nm("ntilde"): cp=241; nm("ograve"): cp=242; nm("oacute"): cp=243;
            nm("ocirc"): cp=244; nm("otilde"): cp=245; nm("ouml"): cp=246;
            nm("divide"): cp=247; nm("oslash"): cp=248; nm("ugrave"): cp=249;
            nm("uacute"): cp=250; nm("ucirc"): cp=251; nm("uuml"): cp=252;
            nm("yacute"): cp=253; nm("thorn"): cp=254; nm("yuml"): cp=255; nm("fnof"): cp=402;
            nm("Alpha"): cp=913; nm("Beta"): cp=914; nm("Gamma"): cp=915; nm("Delta"): cp=916;
            nm("Epsilon"): cp=917; nm("Zeta"): cp=918; nm("Eta"): cp=919; nm("Theta"): cp=920;
            nm("Iota"): cp=921; nm("Kappa"): cp=922; nm("Lambda"): cp=923; nm("Mu"): cp=924;
            nm("Nu"): cp=925; nm("Xi"): cp=926; nm("Omicron"): cp=927; nm("Pi"): cp=928;
            nm("Rho"): cp=929; nm("Sigma"): cp=931; nm("Tau"): cp=932; nm("Upsilon"): cp=933;
            nm("Phi"): cp=934; nm("Chi"): cp=935; nm("Psi"): cp=936; nm("Omega"): cp=937;
            nm("alpha"): cp=945; nm("beta"): cp=946; nm("gamma"): cp=947; nm("delta"): cp=948;
            nm("epsilon"): cp=949; nm("zeta"): cp=950; nm("eta"): cp=951; nm("theta"): cp=952;
            nm("iota"): cp=953; nm("kappa"): cp=954; nm("lambda"): cp=955; nm("mu"): cp=956;
            nm("nu"): cp=957; nm("xi"): cp=958; nm("omicron"): cp=959; nm("pi"): cp=960;
            nm("rho"): cp=961; nm("sigmaf"): cp=962; nm("sigma"): cp=963; nm("tau"): cp=964;
            nm("upsilon"): cp=965; nm("phi"): cp=966; nm("chi"): cp=967; nm("psi"): cp=968;
            nm("omega"): cp=969; nm("thetasym"): cp=977; nm("upsih"): cp=978; nm("piv"): cp=982;
            nm("bull"): cp=8226; nm("hellip"): cp=8230; nm("prime"): cp=8242;
            nm("Prime"): cp=8243; nm("oline"): cp=8254; nm("frasl"): cp=8260;
            nm("weierp"): cp=8472; nm("image"): cp=8465; nm("real"): cp=8476;
            nm("trade"): cp=8482; nm("alefsym"): cp=8501; nm("larr"): cp=8592;
            nm("uarr"): cp=8593; nm("rarr"): cp=8594; nm("darr"): cp=8595; nm("harr"): cp=8596;
            nm("crarr"): cp=8629; nm("lArr"): cp=8656; nm("uArr"): cp=8657; nm("rArr"): cp=8658;
            nm("dArr"): cp=8659; nm("hArr"): cp=8660; nm("forall"): cp=8704;
            nm("part"): cp=8706; nm("exist"): cp=8707; nm("empty"): cp=8709;
            nm("nabla"): cp=8711; nm("isin"): cp=8712; nm("notin"): cp=8713; nm("ni"): cp=8715;
            nm("prod"): cp=8719; nm("sum"): cp=8721; nm("minus"): cp=8722;
            nm("lowast"): cp=8727; nm("radic"): cp=8730; nm("prop"): cp=8733;
            nm("infin"): cp=8734; nm("and"): cp=8743; nm("or"): cp=8744; nm("cap"): cp=8745;
            nm("cup"): cp=8746; nm("int"): cp=8747; nm("there4"): cp=8756; nm("sim"): cp=8764;
            nm("cong"): cp=8773; nm("asymp"): cp=8776; nm("ne"): cp=8800; nm("equiv"): cp=8801;
            nm("le"): cp=8804; nm("ge"): cp=8805; nm("sub"): cp=8834; nm("sup"): cp=8835;
            nm("nsub"): cp=8836; nm("sube"): cp=8838; nm("supe"): cp=8839;
            nm("oplus"): cp=8853; nm("otimes"): cp=8855; nm("perp"): cp=8869;
            nm("sdot"): cp=8901; nm("lceil"): cp=8968; nm("rceil"): cp=8969;
            nm("lfloor"): cp=8970; nm("rfloor"): cp=8971; nm("lang"): cp=9001;
            nm("rang"): cp=9002; nm("loz"): cp=9674; nm("spades"): cp=9824;
            nm("clubs"): cp=9827; nm("hearts"): cp=9829; nm("diams"): cp=9830;
            nm("quot"): cp=34; nm("amp"): cp=38; nm("lt"): cp=60; nm("gt"): cp=62;
            nm("OElig"): cp=338; nm("oelig"): cp=339; nm("Scaron"): cp=352;
            nm("scaron"): cp=353; nm("Yuml"): cp=376; nm("circ"): cp=710; nm("tilde"): cp=732;
            nm("ensp"): cp=8194; nm("emsp"): cp=8195; nm("thinsp"): cp=8201;
            nm("zwnj"): cp=8204; nm("zwj"): cp=8205; nm("lrm"): cp=8206; nm("rlm"): cp=8207;
            nm("ndash"): cp=8211; nm("mdash"): cp=8212; nm("lsquo"): cp=8216;
            nm("rsquo"): cp=8217; nm("sbquo"): cp=8218; nm("ldquo"): cp=8220;
            nm("rdquo"): cp=8221; nm("bdquo"): cp=8222; nm("dagger"): cp=8224;
            nm("Dagger"): cp=8225; nm("permil"): cp=8240; nm("lsaquo"): cp=8249;
            nm("rsaquo"): cp=8250; nm("euro"): cp=8364;
            default: hit = 1'b0;
        endcase
        return {hit, cp[15:0]};
    endfunction

endpackage
`default_nettype wire

### rtl/heu_fifo.sv
// Short job queue between the classifying front and the emitting back.
`default_nettype none
module heu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count on push and pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### rtl/heu_front.sv
// Front: gathers entity names, looks them up, and issues emit jobs.
`default_nettype none
module heu_front
    import heu_pkg::*;
#(
    parameter int MAX_NAME_LEN = 6,
    parameter int LW = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [7:0]                i_byte,
    input  wire logic                      i_last,
    output logic                           o_ready,
    input  wire logic                      i_job_full,
    output logic                           o_job_push,
    output logic [1:0]                     o_job_kind,
    output logic [8*MAX_NAME_LEN-1:0]      o_job_name,
    output logic [LW-1:0]                  o_job_len,
    output logic                           o_job_tail,
    output logic [15:0]                    o_job_val,
    output logic                           o_job_last
);
    logic                      r_collecting;
    logic [LW-1:0]             r_len;
    logic [8*MAX_NAME_LEN-1:0] r_name;
    logic                      acc;
    logic [63:0]               key;
    logic [16:0]               lk;
    logic [LW-1:0]             len_p1;

    assign o_ready = !i_job_full;
    assign acc     = i_valid && o_ready;
    assign len_p1  = r_len + 1'b1;

    // Widen the held name for the table key
    always_comb begin
        key = '0;
        for (int i = 0; i < MAX_NAME_LEN && i < TAB_NAME_LEN; i++) key[i*8 +: 8] = r_name[i*8 +: 8];
    end
    assign lk = ent_lookup(key, 4'(r_len));

    // Classify the incoming byte into a job
    always_comb begin
        o_job_push = 1'b0;
        o_job_kind = JOB_BYTE;
        o_job_name = r_name;
        o_job_len  = r_len;
        o_job_tail = 1'b0;
        o_job_val  = {8'h00, i_byte};
        o_job_last = i_last;
        if (!r_collecting) begin
            o_job_push = acc && !(i_byte == CH_AMP && !i_last);
        end else if (i_byte == CH_SEMI) begin
            o_job_push = acc;
            if (lk[16] && MAX_NAME_LEN <= TAB_NAME_LEN) begin
                o_job_kind = JOB_CP;
                o_job_val  = lk[15:0];
            end else begin
                o_job_kind = JOB_NAME;
                o_job_tail = 1'b1;
            end
        end else if (r_len >= LW'(MAX_NAME_LEN)) begin
            o_job_push = acc;
            o_job_kind = JOB_NAME;
            o_job_tail = 1'b1;
        end else if (i_last) begin
            o_job_push = acc;
            o_job_kind = JOB_NAME;
            o_job_len  = len_p1;
            o_job_name = r_name;
            o_job_name[r_len[$clog2(MAX_NAME_LEN)-1:0]*8 +: 8] = i_byte;
        end
    end

    // Track collection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_len        <= '0;
        end else if (acc) begin
            if (!r_collecting) begin
                r_collecting <= (i_byte == CH_AMP) && !i_last;
                r_len        <= '0;
            end else if (i_byte == CH_SEMI || r_len >= LW'(MAX_NAME_LEN) || i_last) begin
                r_collecting <= 1'b0;
                r_len        <= '0;
            end else begin
                r_len <= len_p1;
            end
        end
    end

    // Store name characters
    always_ff @(posedge i_clk) begin
        if (acc && r_collecting && i_byte != CH_SEMI && r_len < LW'(MAX_NAME_LEN))
            r_name[r_len[$clog2(MAX_NAME_LEN)-1:0]*8 +: 8] <= i_byte;
    end
endmodule
`default_nettype wire

### rtl/heu_back.sv
// Back: turns one job into its run of output bytes, one byte per transaction.
`default_nettype none
module heu_back
    import heu_pkg::*;
#(
    parameter int MAX_NAME_LEN = 6,
    parameter int LW = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_empty,
    output logic                           o_job_pop,
    input  wire logic [1:0]                i_job_kind,
    input  wire logic [8*MAX_NAME_LEN-1:0] i_job_name,
    input  wire logic [LW-1:0]             i_job_len,
    input  wire logic                      i_job_tail,
    input  wire logic [15:0]               i_job_val,
    input  wire logic                      i_job_last,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [7:0]                     o_byte,
    output logic                           o_run_last,
    output logic                           o_string_end
);
    logic [LW-1:0] r_idx;
    logic [LW-1:0] cnt;
    logic [LW-1:0] nidx;
    logic [7:0]    b;
    logic          done;
    logic [15:0]   cp;

    assign cp = i_job_val;

    // Pick the current byte and the run length
    always_comb begin
        b    = 8'h00;
        cnt  = LW'(1);
        nidx = r_idx - 1'b1;
        case (i_job_kind)
            JOB_CP: begin
                if (cp >= 16'h0800) begin
                    cnt = LW'(3);
                    case (r_idx)
                        LW'(0):  b = 8'hE0 | {4'h0, cp[15:12]};
                        LW'(1):  b = 8'h80 | {2'b00, cp[11:6]};
                        default: b = 8'h80 | {2'b00, cp[5:0]};
                    endcase
                end else if (cp >= 16'h0080) begin
                    cnt = LW'(2);
                    b = (r_idx == '0) ? (8'hC0 | {3'b000, cp[10:6]}) : (8'h80 | {2'b00, cp[5:0]});
                end else begin
                    b = cp[7:0];
                end
            end
            JOB_NAME: begin
                cnt = i_job_len + LW'(1) + LW'(i_job_tail);
                if (r_idx == '0) b = CH_AMP;
                else if (r_idx <= i_job_len)
                    b = i_job_name[nidx[$clog2(MAX_NAME_LEN)-1:0]*8 +: 8];
                else b = i_job_val[7:0];
            end
            default: b = i_job_val[7:0];
        endcase
    end

    assign done         = (r_idx == cnt - 1'b1);
    assign o_valid      = !i_job_empty;
    assign o_byte       = b;
    assign o_run_last   = done;
    assign o_string_end = done && i_job_last;
    assign o_job_pop    = o_valid && i_ready && done;

    // Advance through the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= '0;
        else if (o_valid && i_ready) r_idx <= done ? '0 : r_idx + 1'b1;
    end
endmodule
`default_nettype wire

### rtl/html_entity_unescape_core.sv
// Top level of the streaming HTML named-entity unescape core.
// Takes one text byte per transaction and gives the unescaped UTF-8 bytes. A plain byte
// passes as it is; an input that completes an entity or flushes held text gives a run of
// up to MAX_NAME_LEN+2 bytes, sent one per cycle while m_axis_tready is high, while the
// front end accepts input into a two-entry job queue until it is full. Sustained rate
// is one input per cycle while each input gives at most one byte and the output is ready;
// longer runs cost one cycle per byte. Each job is registered in the job queue before
// its bytes go out; m_axis_tuser flags an input's last byte and the string's last byte.
`default_nettype none
module html_entity_unescape_core
    import heu_pkg::*;
#(
    parameter int MAX_NAME_LEN = 6
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser    // [0] run_last, [1] string_end
);
    localparam int LW = $clog2(MAX_NAME_LEN + 3);
    localparam int JW = 2 + 8*MAX_NAME_LEN + LW + 1 + 16 + 1;

    logic                      push, pop, full, empty;
    logic [1:0]                f_kind, b_kind;
    logic [8*MAX_NAME_LEN-1:0] f_name, b_name;
    logic [LW-1:0]             f_len, b_len;
    logic                      f_tail, b_tail, f_last, b_last;
    logic [15:0]               f_val, b_val;
    logic                      run_last, str_end;

    heu_front #(.MAX_NAME_LEN(MAX_NAME_LEN), .LW(LW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .o_ready(s_axis_tready), .i_job_full(full), .o_job_push(push),
        .o_job_kind(f_kind), .o_job_name(f_name), .o_job_len(f_len),
        .o_job_tail(f_tail), .o_job_val(f_val), .o_job_last(f_last)
    );

    heu_fifo #(.WIDTH(JW), .DEPTH(2)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data({f_kind, f_name, f_len, f_tail, f_val, f_last}),
        .o_full(full), .i_pop(pop),
        .o_data({b_kind, b_name, b_len, b_tail, b_val, b_last}), .o_empty(empty)
    );

    heu_back #(.MAX_NAME_LEN(MAX_NAME_LEN), .LW(LW)) u_back (
        .i_clk, .i_rst_n,
        .i_job_empty(empty), .o_job_pop(pop),
        .i_job_kind(b_kind), .i_job_name(b_name), .i_job_len(b_len),
        .i_job_tail(b_tail), .i_job_val(b_val), .i_job_last(b_last),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_byte(m_axis_tdata),
        .o_run_last(run_last), .o_string_end(str_end)
    );

    assign m_axis_tuser = {str_end, run_last};
endmodule
`default_nettype wire
